/* hw/rtl/phe_pkg.sv */
`timescale 1ns / 1ps

package phe_pkg;

	localparam int MAX_SYMBOLS   = 256;
	localparam int MAX_PIXELS    = 65536;
	localparam int MAX_CODE_BITS = 32;

	localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_BUILD  = 2'd1;
	localparam logic [1:0] CMD_ENCODE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] pixel_value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] code_bits;
		logic [5:0]  code_size;
		logic [21:0] total_bits;
		logic [19:0] original_bits;
		logic [8:0]  distinct_count;
		logic [1:0]  status;
	} res_t;

	// Code word of a tree node: length and right-aligned path bits.
	typedef struct packed {
		logic [5:0]  len;
		logic [31:0] bits;
	} path_t;

	typedef struct packed {
		logic [8:0] left;
		logic [8:0] right;
	} kids_t;

	// Path of a child: one more bit below the parent, until the length limit is reached.
	function automatic path_t child_path(path_t p, logic bit_v, logic [5:0] max_len);
		path_t r;
		if (p.len < max_len) begin
			r.bits = {p.bits[30:0], bit_v};
			r.len  = p.len + 6'd1;
		end else begin
			r = p;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pixel_huffman_table_encoder_unit.sv */
`timescale 1ns / 1ps

// Channel  Direction  Payload            Transfer when
// cmd      in         phe_pkg::cmd_t     cmd_valid && cmd_ready
// res      out        phe_pkg::res_t     res_valid && res_ready
//
// Load of a new value writes its slot and weight when the command is taken; a value already
// seen takes a weight memory read-modify-write. Encode does a slot lookup, then a code memory read.
// Build runs a sorted node list in memory: each insertion reads and compares every list entry
// that it shifts, for d distinct values; then come the merges, code assignment per inner node
// and the bit total per value.
// A command is taken only while idle and with the result register empty.
// Reset and the clear command empty the seen marks and counters; no memory sweep.

module pixel_huffman_table_encoder_unit #(
	parameter int MAX_SYMBOLS   = phe_pkg::MAX_SYMBOLS,
	parameter int MAX_PIXELS    = phe_pkg::MAX_PIXELS,
	parameter int MAX_CODE_BITS = phe_pkg::MAX_CODE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  phe_pkg::cmd_t cmd_data,
	output logic          res_valid,
	input  logic          res_ready,
	output phe_pkg::res_t res_data
);

	localparam int PCNT_W = $clog2(MAX_PIXELS + 1);
	localparam int PROD_W = PCNT_W + 6;
	localparam int SUM_W  = ((PROD_W > 22) ? PROD_W : 22) + 1;

	typedef struct packed {
		logic [8:0]        id;
		logic [PCNT_W-1:0] w;
	} ord_t;

	typedef enum logic [18:0] {
		S_IDLE    = 19'b0000000000000000001,
		S_LD_RD   = 19'b0000000000000000010,
		S_LD_WR   = 19'b0000000000000000100,
		S_EN_RD   = 19'b0000000000000001000,
		S_EN_OUT  = 19'b0000000000000010000,
		S_BI_RD   = 19'b0000000000000100000,
		S_BI_GOT  = 19'b0000000000001000000,
		S_INS_RD  = 19'b0000000000010000000,
		S_INS_CMP = 19'b0000000000100000000,
		S_MERGE   = 19'b0000000001000000000,
		S_M_A     = 19'b0000000010000000000,
		S_M_B     = 19'b0000000100000000000,
		S_PW_INIT = 19'b0000001000000000000,
		S_PW_RD   = 19'b0000010000000000000,
		S_PW_A    = 19'b0000100000000000000,
		S_PW_B    = 19'b0001000000000000000,
		S_TOT_RD  = 19'b0010000000000000000,
		S_TOT_ACC = 19'b0100000000000000000,
		S_DONE    = 19'b1000000000000000000
	} state_t;

	state_t state_q;

	logic [255:0]      seen_q;
	logic [8:0]        distinct_q;
	logic [PCNT_W-1:0] pixel_q;
	logic              built_q;
	logic              res_valid_q;
	phe_pkg::res_t     res_q;

	logic [8:0]  head_q, tail_q, k_q, i_q;
	logic [7:0]  made_q, kp_q;
	logic        strict_q;
	ord_t        key_q, a_q;
	logic [21:0] total_q;

	// Memories
	logic [7:0]          slot_mem [256];
	logic [PCNT_W-1:0]   weight_mem [256];
	ord_t                ord_mem [512];
	phe_pkg::kids_t      child_mem [256];
	phe_pkg::path_t      path_mem [512];

	logic [7:0]        slot_rd_q;
	logic [PCNT_W-1:0] weight_rd_q;
	ord_t              ord_rd_q;
	phe_pkg::kids_t    child_rd_q;
	phe_pkg::path_t    path_rd_q;

	logic              slot_we, slot_re;
	logic [7:0]        slot_wa, slot_wd, slot_ra;
	logic              weight_we, weight_re;
	logic [7:0]        weight_wa, weight_ra;
	logic [PCNT_W-1:0] weight_wd;
	logic              ord_we, ord_re;
	logic [8:0]        ord_wa, ord_ra;
	ord_t              ord_wd;
	logic              child_we, child_re;
	logic [7:0]        child_wa, child_ra;
	phe_pkg::kids_t    child_wd;
	logic              path_we, path_re;
	logic [8:0]        path_wa, path_ra;
	phe_pkg::path_t    path_wd;

	logic        acc;
	logic        cur_seen;
	logic        ld_full;
	logic        move;
	logic [8:0]  leaf_slot;
	logic [8:0]  inner_id;
	logic [8:0]  root_id;
	logic [8:0]  parent_id;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  sum;
	logic [PCNT_W+22:0] orig_wide;

	assign cmd_ready = (state_q == S_IDLE) && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign acc       = cmd_valid && cmd_ready;
	assign cur_seen  = seen_q[cmd_data.pixel_value];
	assign ld_full   = (pixel_q >= PCNT_W'(MAX_PIXELS)) ||
		(!cur_seen && (distinct_q >= 9'(MAX_SYMBOLS)));
	// Leaves keep their order among equal weights; a merged node goes before its equals.
	assign move      = strict_q ? (ord_rd_q.w > key_q.w) : (ord_rd_q.w >= key_q.w);
	assign leaf_slot = distinct_q - 9'd1 - i_q;
	assign inner_id  = 9'd256 + {1'b0, made_q};
	assign root_id   = 9'd255 + {1'b0, made_q};
	assign parent_id = 9'd255 + {1'b0, kp_q};
	assign prod      = PROD_W'(weight_rd_q) * PROD_W'(path_rd_q.len);
	assign sum       = SUM_W'(total_q) + SUM_W'(prod);
	assign orig_wide = (PCNT_W+23)'(pixel_q) << 3;

	always_comb begin
		slot_we   = 1'b0;
		slot_re   = 1'b0;
		slot_wa   = cmd_data.pixel_value;
		slot_wd   = distinct_q[7:0];
		slot_ra   = cmd_data.pixel_value;
		weight_we = 1'b0;
		weight_re = 1'b0;
		weight_wa = distinct_q[7:0];
		weight_wd = PCNT_W'(1);
		weight_ra = slot_rd_q;
		ord_we    = 1'b0;
		ord_re    = 1'b0;
		ord_wa    = k_q;
		ord_wd    = key_q;
		ord_ra    = k_q - 9'd1;
		child_we  = 1'b0;
		child_re  = 1'b0;
		child_wa  = made_q;
		child_wd  = '{left: a_q.id, right: ord_rd_q.id};
		child_ra  = kp_q - 8'd1;
		path_we   = 1'b0;
		path_re   = 1'b0;
		path_wa   = child_rd_q.left;
		path_wd   = phe_pkg::child_path(path_rd_q, 1'b0, 6'(MAX_CODE_BITS));
		path_ra   = {1'b0, slot_rd_q};
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					slot_re = 1'b1;
					if (cmd_data.command == phe_pkg::CMD_LOAD && !ld_full && !cur_seen) begin
						slot_we   = 1'b1;
						weight_we = 1'b1;
					end
				end
			end
			S_LD_RD: weight_re = 1'b1;
			S_LD_WR: begin
				weight_we = 1'b1;
				weight_wa = slot_rd_q;
				weight_wd = weight_rd_q + PCNT_W'(1);
			end
			S_EN_RD: path_re = 1'b1;
			S_BI_RD: begin
				weight_re = 1'b1;
				weight_ra = leaf_slot[7:0];
			end
			S_INS_RD: begin
				if (k_q == head_q) begin
					ord_we = 1'b1;
				end else begin
					ord_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				ord_we = 1'b1;
				if (move) begin
					ord_wd = ord_rd_q;
				end
			end
			S_MERGE: begin
				ord_re = 1'b1;
				ord_ra = head_q;
			end
			S_M_A: begin
				ord_re = 1'b1;
				ord_ra = head_q + 9'd1;
			end
			S_M_B: child_we = 1'b1;
			S_PW_INIT: begin
				path_we = 1'b1;
				path_wa = (made_q == 8'd0) ? 9'd0 : root_id;
				path_wd = '0;
			end
			S_PW_RD: begin
				child_re = 1'b1;
				path_re  = 1'b1;
				path_ra  = parent_id;
			end
			S_PW_A: path_we = 1'b1;
			S_PW_B: begin
				path_we = 1'b1;
				path_wa = child_rd_q.right;
				path_wd = phe_pkg::child_path(path_rd_q, 1'b1, 6'(MAX_CODE_BITS));
			end
			S_TOT_RD: begin
				if (i_q != distinct_q) begin
					weight_re = 1'b1;
					weight_ra = i_q[7:0];
					path_re   = 1'b1;
					path_ra   = {1'b0, i_q[7:0]};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		if (slot_re) slot_rd_q <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (weight_we) weight_mem[weight_wa] <= weight_wd;
		if (weight_re) weight_rd_q <= weight_mem[weight_ra];
	end

	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_wa] <= ord_wd;
		if (ord_re) ord_rd_q <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		if (child_re) child_rd_q <= child_mem[child_ra];
	end

	always_ff @(posedge clk) begin
		if (path_we) path_mem[path_wa] <= path_wd;
		if (path_re) path_rd_q <= path_mem[path_ra];
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc && cmd_data.command == phe_pkg::CMD_BUILD) begin
					head_q   <= '0;
					tail_q   <= '0;
					i_q      <= '0;
					made_q   <= '0;
					total_q  <= '0;
				end
			end
			S_BI_GOT: begin
				key_q    <= '{id: leaf_slot, w: weight_rd_q};
				strict_q <= 1'b1;
				k_q      <= tail_q;
			end
			S_INS_RD: begin
				if (k_q == head_q) begin
					tail_q <= tail_q + 9'd1;
					if (strict_q) i_q <= i_q + 9'd1;
				end
			end
			S_INS_CMP: begin
				if (move) begin
					k_q <= k_q - 9'd1;
				end else begin
					tail_q <= tail_q + 9'd1;
					if (strict_q) i_q <= i_q + 9'd1;
				end
			end
			S_M_A: a_q <= ord_rd_q;
			S_M_B: begin
				key_q    <= '{id: inner_id, w: a_q.w + ord_rd_q.w};
				head_q   <= head_q + 9'd2;
				made_q   <= made_q + 8'd1;
				strict_q <= 1'b0;
				k_q      <= tail_q;
			end
			S_PW_INIT: begin
				kp_q <= made_q;
				i_q  <= '0;
			end
			S_PW_B: kp_q <= kp_q - 8'd1;
			S_TOT_ACC: begin
				total_q <= (sum > SUM_W'(phe_pkg::TOTAL_MAX)) ? phe_pkg::TOTAL_MAX : sum[21:0];
				i_q     <= i_q + 9'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			distinct_q  <= '0;
			pixel_q     <= '0;
			built_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (cmd_data.command)
							phe_pkg::CMD_LOAD: begin
								built_q <= 1'b0;
								if (ld_full) begin
									res_valid_q <= 1'b1;
									res_q       <= '{code_bits: '0, code_size: '0,
										total_bits: '0, original_bits: '0,
										distinct_count: '0, status: phe_pkg::ST_FULL};
								end else if (!cur_seen) begin
									seen_q[cmd_data.pixel_value] <= 1'b1;
									distinct_q <= distinct_q + 9'd1;
									pixel_q    <= pixel_q + PCNT_W'(1);
								end else begin
									state_q <= S_LD_RD;
								end
							end
							phe_pkg::CMD_BUILD: begin
								state_q <= (distinct_q == 9'd0) ? S_DONE : S_BI_RD;
							end
							phe_pkg::CMD_ENCODE: begin
								if (!built_q || !cur_seen) begin
									res_valid_q <= 1'b1;
									res_q       <= '{code_bits: '0, code_size: '0,
										total_bits: '0, original_bits: '0,
										distinct_count: '0, status: phe_pkg::ST_ABSENT};
								end else begin
									state_q <= S_EN_RD;
								end
							end
							default: begin
								seen_q     <= '0;
								distinct_q <= '0;
								pixel_q    <= '0;
								built_q    <= 1'b0;
							end
						endcase
					end
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: begin
					pixel_q <= pixel_q + PCNT_W'(1);
					state_q <= S_IDLE;
				end
				S_EN_RD: state_q <= S_EN_OUT;
				S_EN_OUT: begin
					res_valid_q <= 1'b1;
					res_q       <= '{code_bits: path_rd_q.bits, code_size: path_rd_q.len,
						total_bits: '0, original_bits: '0,
						distinct_count: '0, status: phe_pkg::ST_OK};
					state_q     <= S_IDLE;
				end
				S_BI_RD:  state_q <= S_BI_GOT;
				S_BI_GOT: state_q <= S_INS_RD;
				S_INS_RD: begin
					if (k_q == head_q) begin
						state_q <= (strict_q && (i_q + 9'd1 != distinct_q)) ? S_BI_RD : S_MERGE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (move) begin
						state_q <= S_INS_RD;
					end else begin
						state_q <= (strict_q && (i_q + 9'd1 != distinct_q)) ? S_BI_RD : S_MERGE;
					end
				end
				S_MERGE:   state_q <= (tail_q - head_q == 9'd1) ? S_PW_INIT : S_M_A;
				S_M_A:     state_q <= S_M_B;
				S_M_B:     state_q <= S_INS_RD;
				S_PW_INIT: state_q <= (made_q == 8'd0) ? S_TOT_RD : S_PW_RD;
				S_PW_RD:   state_q <= S_PW_A;
				S_PW_A:    state_q <= S_PW_B;
				S_PW_B:    state_q <= (kp_q == 8'd1) ? S_TOT_RD : S_PW_RD;
				S_TOT_RD:  state_q <= (i_q == distinct_q) ? S_DONE : S_TOT_ACC;
				S_TOT_ACC: state_q <= S_TOT_RD;
				S_DONE: begin
					res_valid_q <= 1'b1;
					res_q       <= '{code_bits: '0, code_size: '0,
						total_bits: total_q, original_bits: orig_wide[19:0],
						distinct_count: distinct_q, status: phe_pkg::ST_OK};
					built_q     <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> !res_valid)
		else $error("command taken while a result is pending");

	a_list_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE || state_q == S_M_A || state_q == S_M_B) |-> (tail_q > head_q))
		else $error("node list empty during merge");

	a_merge_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M_B) |-> (tail_q - head_q >= 9'd2))
		else $error("merge with fewer than two nodes");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> res_valid)
		else $error("build finished without a result");

endmodule

/* tb/pixel_huffman_table_encoder_unit_checker.sv */
`timescale 1ns / 1ps

module pixel_huffman_table_encoder_unit_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  phe_pkg::cmd_t cmd_data,
	input  logic          res_valid,
	input  logic          res_ready,
	input  phe_pkg::res_t res_data,
	output int            failures,
	output int            pending
);

	bit             seen[256];
	int             slot_of[256];
	int             weight[511];
	int             left_kid[255];
	int             right_kid[255];
	int             code_len[256];
	logic [31:0]    word_of[256];
	int             distinct;
	int             pixels;
	bit             built;
	phe_pkg::res_t  awaited_codes[$];
	int             mismatches;

	function automatic void clear_tables();
		for (int i = 0; i < 256; i++) seen[i] = 0;
		distinct = 0;
		pixels = 0;
		built = 0;
	endfunction

	// Forms the tree and the code table; returns the saturated bit total.
	function automatic int build_codes();
		int order[256];
		int plen[511];
		logic [31:0] pbits[511];
		int n, made, key, k, a, b, id, parent;
		longint total;
		n = distinct;
		made = 0;
		total = 0;
		for (int i = 0; i < n; i++) order[i] = n - 1 - i;
		while (n >= 2) begin
			for (int i = 1; i < n; i++) begin
				key = order[i];
				k = i;
				while (k > 0 && weight[order[k - 1]] > weight[key]) begin
					order[k] = order[k - 1];
					k--;
				end
				order[k] = key;
			end
			a = order[0];
			b = order[1];
			id = 256 + made;
			weight[id] = weight[a] + weight[b];
			left_kid[made] = a;
			right_kid[made] = b;
			made++;
			order[0] = id;
			for (int i = 1; i < n - 1; i++) order[i] = order[i + 1];
			n--;
		end
		for (int i = 0; i < 511; i++) begin
			plen[i] = 0;
			pbits[i] = '0;
		end
		for (int m = made - 1; m >= 0; m--) begin
			parent = 256 + m;
			for (int side = 0; side < 2; side++) begin
				id = (side == 0) ? left_kid[m] : right_kid[m];
				if (plen[parent] < phe_pkg::MAX_CODE_BITS) begin
					pbits[id] = {pbits[parent][30:0], side[0]};
					plen[id] = plen[parent] + 1;
				end else begin
					pbits[id] = pbits[parent];
					plen[id] = plen[parent];
				end
			end
		end
		for (int i = 0; i < distinct; i++) begin
			code_len[i] = plen[i];
			word_of[i] = pbits[i];
			total += longint'(weight[i]) * plen[i];
			if (total > phe_pkg::TOTAL_MAX) total = phe_pkg::TOTAL_MAX;
		end
		return int'(total);
	endfunction

	function automatic void predict(phe_pkg::cmd_t c);
		phe_pkg::res_t r;
		int v;
		r = '0;
		v = c.pixel_value;
		case (c.command)
			phe_pkg::CMD_LOAD: begin
				built = 0;
				if (pixels >= phe_pkg::MAX_PIXELS ||
					(!seen[v] && distinct >= phe_pkg::MAX_SYMBOLS)) begin
					r.status = phe_pkg::ST_FULL;
					awaited_codes.push_back(r);
				end else begin
					if (!seen[v]) begin
						seen[v] = 1;
						slot_of[v] = distinct;
						weight[distinct] = 0;
						distinct++;
					end
					weight[slot_of[v]]++;
					pixels++;
				end
			end
			phe_pkg::CMD_BUILD: begin
				r.total_bits = 22'(build_codes());
				r.original_bits = 20'(pixels * 8);
				r.distinct_count = 9'(distinct);
				built = 1;
				awaited_codes.push_back(r);
			end
			phe_pkg::CMD_ENCODE: begin
				if (!built || !seen[v]) begin
					r.status = phe_pkg::ST_ABSENT;
				end else begin
					r.code_bits = word_of[slot_of[v]];
					r.code_size = 6'(code_len[slot_of[v]]);
				end
				awaited_codes.push_back(r);
			end
			default: clear_tables();
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		phe_pkg::res_t want;
		if (!arst_n) begin
			clear_tables();
			awaited_codes.delete();
			failures <= 0;
			pending <= 0;
			mismatches = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (awaited_codes.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %h", res_data);
					mismatches++;
				end else begin
					want = awaited_codes.pop_front();
					if (want !== res_data) begin
						if (mismatches < 10)
							$display("result mismatch: expected %h actual %h", want, res_data);
						mismatches++;
					end
				end
			end
			if (cmd_valid && cmd_ready) predict(cmd_data);
			failures <= mismatches;
			pending <= awaited_codes.size();
		end
	end

endmodule

/* tb/pixel_huffman_table_encoder_unit_tb.sv */
`timescale 1ns / 1ps

module pixel_huffman_table_encoder_unit_tb;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           cmd_valid = 0;
	logic           cmd_ready;
	phe_pkg::cmd_t  cmd_data = '0;
	logic           res_valid;
	logic           res_ready = 0;
	phe_pkg::res_t  res_data;
	logic           cmd_taken = 0;
	logic           res_taken = 0;
	int             failures;
	int             pending;
	bit             steady = 0;

	always #5 clk = ~clk;

	pixel_huffman_table_encoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
	);

	pixel_huffman_table_encoder_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.failures(failures), .pending(pending)
	);

	// Transfer flags, seen at the falling edge after the rising edge they happened on.
	always @(posedge clk) begin
		cmd_taken <= cmd_valid && cmd_ready;
		res_taken <= res_valid && res_ready;
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				res_ready = 0;
				repeat (stall) @(negedge clk);
			end
			res_ready = 1;
			do @(negedge clk); while (!res_taken);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send(logic [1:0] op, logic [7:0] pix);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_valid = 0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid = 1;
		cmd_data = '{command: op, pixel_value: pix};
		do @(negedge clk); while (!cmd_taken);
	endtask

	task automatic drain();
		cmd_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	initial begin
		int alphabet, loads, base;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(phe_pkg::CMD_ENCODE, 8'd0);
		send(phe_pkg::CMD_BUILD, 8'd0);
		send(phe_pkg::CMD_LOAD, 8'd0);
		send(phe_pkg::CMD_BUILD, 8'd0);
		send(phe_pkg::CMD_ENCODE, 8'd0);
		send(phe_pkg::CMD_ENCODE, 8'd5);
		send(phe_pkg::CMD_LOAD, 8'd255);
		send(phe_pkg::CMD_LOAD, 8'd255);
		send(phe_pkg::CMD_LOAD, 8'd170);
		send(phe_pkg::CMD_ENCODE, 8'd255);
		send(phe_pkg::CMD_BUILD, 8'd0);
		send(phe_pkg::CMD_ENCODE, 8'd255);
		send(phe_pkg::CMD_ENCODE, 8'd0);
		send(phe_pkg::CMD_ENCODE, 8'd170);
		send(phe_pkg::CMD_ENCODE, 8'd85);
		send(phe_pkg::CMD_CLEAR, 8'd0);
		send(phe_pkg::CMD_ENCODE, 8'd255);
		drain();

		// Every value once, then a skewed spread, so the tree reaches its full size.
		steady = 1;
		send(phe_pkg::CMD_CLEAR, 8'd0);
		for (int i = 0; i < 456; i++)
			send(phe_pkg::CMD_LOAD, (i < 256) ? 8'(i) : 8'($urandom_range(0, 15)));
		send(phe_pkg::CMD_BUILD, 8'd0);
		for (int i = 0; i < 8; i++) send(phe_pkg::CMD_ENCODE, 8'($urandom));
		drain();
		steady = 0;

		for (int round = 0; round < 110; round++) begin
			steady = (round % 9 == 4);
			send(phe_pkg::CMD_CLEAR, 8'($urandom));
			alphabet = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			base = $urandom_range(0, 255);
			loads = $urandom_range(0, 12);
			for (int i = 0; i < loads; i++)
				send(phe_pkg::CMD_LOAD, 8'(base + $urandom_range(0, alphabet - 1)));
			send(phe_pkg::CMD_BUILD, 8'($urandom));
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(0, 7) == 0)
					send(2'($urandom), 8'($urandom));
				else
					send(phe_pkg::CMD_ENCODE, ($urandom_range(0, 3) == 0) ? 8'($urandom)
						: 8'(base + $urandom_range(0, alphabet - 1)));
			end
			if (round == 50) begin
				cmd_valid = 0;
				while (pending != 0) @(negedge clk);
			end
		end
		drain();

		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
